>>> sv/bbc_pkg.sv
// Shared types and constants of the Bollinger band calculator.
package bbc_pkg;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_WINDOW_LENGTH   = 1'b0,
        CFG_BAND_MULTIPLIER = 1'b1
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int LEN_CFG_W  = 7;
    localparam int MULT_W     = 16;
    localparam int MULT_FRAC  = 8;

    // Sample, variance and deviation widths.
    localparam int SAMPLE_W = 32;
    localparam int VAR_W    = 64;
    localparam int DEV_W    = 32;

endpackage

>>> sv/bollinger_band_calculator_unit.sv
// Bollinger band calculator top level: window memory, sequencer and band output.
//
// Input channel (i_valid / o_stall) carries one Q16.16 sample and a time tag.
// A transaction is taken only while the sequencer is idle; o_stall stays high
// until the result has moved into the output register.
// Each sample goes into a circular window memory (WINDOW entries, registered
// read port). Once the last L samples are present (L is the window length
// register clamped to 2..WINDOW) two read passes follow: one sums the samples
// for the floor mean, one accumulates squared distances from the mean. A shared
// restoring divider divides both totals by L, a serial square root unit gives
// the deviation, and one 16x32 multiply scales it.
// With fewer than L samples present the result goes straight to the result register,
// flagged invalid with zero bands; with L present the two passes, the divider
// and the root unit come first. One item at a time: the next sample
// is taken the cycle after the result is registered.
// Output channel (o_valid / i_stall) is a result register. When the receiver
// stalls, the sequencer holds its next result until the register frees.
// Synchronous reset empties the window (fill count and write slot to zero)
// and loads window length 20 and multiplier 2.0; memory contents stay as is.
module bollinger_band_calculator_unit #(
    parameter int WINDOW = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // sample input
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [31:0]             i_sample,
    input  logic [31:0]                    i_time_tag,
    // band output
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_band_valid,
    output logic signed [31:0]             o_lower_band,
    output logic signed [31:0]             o_middle_band,
    output logic signed [31:0]             o_upper_band,
    output logic [31:0]                    o_echoed_time
);

    import bbc_pkg::*;

    localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int LW    = $clog2(WINDOW + 1);
    localparam int SW    = SAMPLE_W + AW;       // signed window sum
    localparam int DW    = VAR_W + AW;          // sum of squares, divider width
    localparam int CW    = $clog2(DW + 1);
    localparam int PW    = MULT_W + DEV_W;      // multiplier * deviation
    localparam int OW    = PW - MULT_FRAC;      // band offset
    localparam int BW    = OW + 2;              // band before saturation

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SUM  = 9'b000000010,
        S_DIV1 = 9'b000000100,
        S_SQ   = 9'b000001000,
        S_DIV2 = 9'b000010000,
        S_SQRT = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_BAND = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [LEN_CFG_W-1:0] r_len_cfg;
    logic [MULT_W-1:0]    r_mult;

    // window bookkeeping
    logic [SAMPLE_W-1:0]  r_win_mem [WINDOW];
    logic [SAMPLE_W-1:0]  r_rd_data;
    logic [AW-1:0]        r_wpos;
    logic [LW-1:0]        r_fill;
    logic [AW-1:0]        r_start;
    logic [AW-1:0]        r_ptr;
    logic [LW-1:0]        r_cnt;
    logic [LW-1:0]        r_len;
    logic                 r_v1, r_v2, r_v3;

    // datapath
    logic signed [SW-1:0] r_sum;
    logic signed [31:0]   r_mid;
    logic [DEV_W-1:0]     r_absdiff;
    logic [VAR_W-1:0]     r_sq;
    logic [DW-1:0]        r_acc;
    logic [VAR_W-1:0]     r_var;
    logic [DEV_W-1:0]     r_dev;
    logic [PW-1:0]        r_prod;
    logic signed [31:0]   r_lo, r_hi;
    logic                 r_band_ok;
    logic [31:0]          r_time;
    logic                 r_div_start;
    logic                 r_sqrt_start;

    // output register
    logic                 r_o_valid;
    logic                 r_o_band_valid;
    logic signed [31:0]   r_o_lower, r_o_middle, r_o_upper;
    logic [31:0]          r_o_time;

    logic [31:0]          w_len_wide;
    logic [LW-1:0]        w_len;
    logic                 w_in_acc;
    logic [AW-1:0]        w_wpos_next;
    logic [LW-1:0]        w_fill_next;
    logic                 w_rd_en;
    logic                 w_out_free;
    logic [SW-1:0]        w_sum_mag;
    logic [DW-1:0]        w_dividend;
    logic [CW-1:0]        w_steps;
    logic                 w_div_done;
    logic [DW-1:0]        w_div_q;
    logic [LW-1:0]        w_div_r;
    logic signed [SW:0]   w_mid_full;
    logic                 w_sqrt_done;
    logic [DEV_W-1:0]     w_sqrt_root;
    logic signed [32:0]   w_diff;
    logic [OW-1:0]        w_off;
    logic signed [BW-1:0] w_lo_full, w_hi_full;
    logic signed [31:0]   w_lo_sat, w_hi_sat;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg <= LEN_CFG_W'(20);
            r_mult    <= MULT_W'(512);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WINDOW_LENGTH:   r_len_cfg <= i_cfg_data[LEN_CFG_W-1:0];
                CFG_BAND_MULTIPLIER: r_mult    <= i_cfg_data[MULT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the window length into 2..WINDOW.
    always_comb begin
        w_len_wide = 32'(r_len_cfg);
        if (w_len_wide < 32'd2) begin
            w_len_wide = 32'd2;
        end
        if (w_len_wide > 32'(WINDOW)) begin
            w_len_wide = 32'(WINDOW);
        end
        w_len = w_len_wide[LW-1:0];
    end

    // ---------------------------------------------------------------
    // Handshake and window bookkeeping
    // ---------------------------------------------------------------
    assign o_stall     = (r_state != S_IDLE);
    assign w_in_acc    = i_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_o_valid || !i_stall;
    assign w_wpos_next = (r_wpos == AW'(WINDOW - 1)) ? '0 : r_wpos + AW'(1);
    assign w_fill_next = (r_fill == LW'(WINDOW)) ? r_fill : r_fill + LW'(1);

    // Reads come after the write of the newest sample,
    // so every entry read has already been written back.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_win_mem[r_wpos] <= i_sample;
        end
        r_rd_data <= r_win_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_fill <= '0;
        end else if (w_in_acc) begin
            r_wpos <= w_wpos_next;
            r_fill <= w_fill_next;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign w_rd_en = ((r_state == S_SUM) || (r_state == S_SQ)) && (r_cnt != r_len);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (w_fill_next >= w_len) ? S_SUM : S_OUT;
                end
            end
            S_SUM: begin
                if ((r_cnt == r_len) && !r_v1) begin
                    n_state = S_DIV1;
                end
            end
            S_DIV1: begin
                if (w_div_done) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                if ((r_cnt == r_len) && !r_v1 && !r_v2 && !r_v3) begin
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                if (w_div_done) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (w_sqrt_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_BAND;
            S_BAND: n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_v1         <= w_rd_en;
            r_v2         <= (r_state == S_SQ) && r_v1;
            r_v3         <= r_v2;
            // pulse the divider and the root unit on entry to their states
            r_div_start  <= ((r_state == S_SUM) && (n_state == S_DIV1)) ||
                            ((r_state == S_SQ) && (n_state == S_DIV2));
            r_sqrt_start <= (r_state == S_DIV2) && (n_state == S_SQRT);
        end
    end

    // Read pointer walks backward from the newest sample, L entries.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_start   <= r_wpos;
            r_ptr     <= r_wpos;
            r_cnt     <= '0;
            r_len     <= w_len;
            r_time    <= i_time_tag;
            r_band_ok <= (w_fill_next >= w_len);
            r_sum     <= '0;
        end else if (w_rd_en) begin
            r_ptr <= (r_ptr == '0) ? AW'(WINDOW - 1) : r_ptr - AW'(1);
            r_cnt <= r_cnt + LW'(1);
        end else if ((r_state == S_SUM) && (n_state == S_DIV1)) begin
            // rewind for the deviation pass
            r_ptr <= r_start;
            r_cnt <= '0;
        end
        if ((r_state == S_SUM) && r_v1) begin
            r_sum <= r_sum + {{(SW-SAMPLE_W){r_rd_data[SAMPLE_W-1]}}, r_rd_data};
        end
    end

    // ---------------------------------------------------------------
    // Mean: floor division of the signed sum by L
    // ---------------------------------------------------------------
    assign w_sum_mag  = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign w_dividend = (r_state == S_DIV1) ? {w_sum_mag, {(DW-SW){1'b0}}} : r_acc;
    assign w_steps    = (r_state == S_DIV1) ? CW'(SW) : CW'(DW);

    bbc_divider #(
        .DW (DW),
        .LW (LW)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (r_len),
        .i_steps     (w_steps),
        .o_done      (w_div_done),
        .o_quotient  (w_div_q),
        .o_remainder (w_div_r)
    );

    // Round toward minus infinity for a negative sum.
    always_comb begin
        if (r_sum[SW-1]) begin
            w_mid_full = -$signed({1'b0, w_div_q[SW-1:0]}) -
                         ((w_div_r != '0) ? (SW+1)'(1) : (SW+1)'(0));
        end else begin
            w_mid_full = $signed({1'b0, w_div_q[SW-1:0]});
        end
    end

    // ---------------------------------------------------------------
    // Deviation pass: |x - mid|, square, accumulate
    // ---------------------------------------------------------------
    assign w_diff = $signed({r_rd_data[SAMPLE_W-1], r_rd_data}) - $signed({r_mid[31], r_mid});

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIV1) && w_div_done) begin
            r_mid <= w_mid_full[31:0];
            r_acc <= '0;
        end
        if (r_v1) begin
            r_absdiff <= w_diff[32] ? DEV_W'(-w_diff) : DEV_W'(w_diff);
        end
        if (r_v2) begin
            r_sq <= r_absdiff * r_absdiff;
        end
        if (r_v3) begin
            r_acc <= r_acc + DW'(r_sq);
        end
        if ((r_state == S_DIV2) && w_div_done) begin
            r_var <= w_div_q[VAR_W-1:0];
        end
        if (w_sqrt_done) begin
            r_dev <= w_sqrt_root;
        end
        if (r_state == S_MUL) begin
            r_prod <= PW'(r_mult) * PW'(r_dev);
        end
        if (r_state == S_BAND) begin
            r_lo <= w_lo_sat;
            r_hi <= w_hi_sat;
        end
    end

    bbc_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sqrt_start),
        .i_radicand (r_var),
        .o_done     (w_sqrt_done),
        .o_root     (w_sqrt_root)
    );

    // ---------------------------------------------------------------
    // Bands: middle -/+ offset, saturated to 32 bits
    // ---------------------------------------------------------------
    assign w_off     = r_prod[PW-1:MULT_FRAC];
    assign w_lo_full = $signed({{(BW-32){r_mid[31]}}, r_mid}) - $signed({2'b00, w_off});
    assign w_hi_full = $signed({{(BW-32){r_mid[31]}}, r_mid}) + $signed({2'b00, w_off});

    always_comb begin
        w_lo_sat = w_lo_full[31:0];
        if (!w_lo_full[BW-1] && (w_lo_full[BW-2:31] != '0)) begin
            w_lo_sat = 32'sh7FFF_FFFF;
        end else if (w_lo_full[BW-1] && (w_lo_full[BW-2:31] != '1)) begin
            w_lo_sat = 32'sh8000_0000;
        end
        w_hi_sat = w_hi_full[31:0];
        if (!w_hi_full[BW-1] && (w_hi_full[BW-2:31] != '0)) begin
            w_hi_sat = 32'sh7FFF_FFFF;
        end else if (w_hi_full[BW-1] && (w_hi_full[BW-2:31] != '1)) begin
            w_hi_sat = 32'sh8000_0000;
        end
    end

    // ---------------------------------------------------------------
    // Output register: load from the sequencer, drop on transaction
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_o_band_valid <= r_band_ok;
            r_o_lower      <= r_band_ok ? r_lo  : '0;
            r_o_middle     <= r_band_ok ? r_mid : '0;
            r_o_upper      <= r_band_ok ? r_hi  : '0;
            r_o_time       <= r_time;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_band_valid  = r_o_band_valid;
    assign o_lower_band  = r_o_lower;
    assign o_middle_band = r_o_middle;
    assign o_upper_band  = r_o_upper;
    assign o_echoed_time = r_o_time;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LW'(WINDOW))
        else $error("fill count exceeds window depth");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken without leaving idle");

    a_result_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_OUT))
        else $error("result appeared outside the output step");

    a_band_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_band_valid) |->
            (o_lower_band <= o_middle_band) && (o_middle_band <= o_upper_band))
        else $error("bands out of order");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_band_valid) |->
            (o_lower_band == '0) && (o_middle_band == '0) && (o_upper_band == '0))
        else $error("invalid result carries nonzero bands");

endmodule

>>> sv/bbc_divider.sv
// Restoring divider, one quotient bit per cycle, small divisor.
module bbc_divider #(
    parameter int DW = 70,
    parameter int LW = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DW-1:0]            i_dividend,
    input  logic [LW-1:0]            i_divisor,
    input  logic [$clog2(DW+1)-1:0]  i_steps,
    output logic                     o_done,
    output logic [DW-1:0]            o_quotient,
    output logic [LW-1:0]            o_remainder
);

    localparam int CW = $clog2(DW+1);

    logic [DW-1:0] r_q;
    logic [LW-1:0] r_rem;
    logic [LW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [LW:0]   w_shift;
    logic          w_take;
    logic [LW:0]   w_diff;

    assign w_shift = {r_rem, r_q[DW-1]};
    assign w_take  = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], w_take};
            r_rem <= w_take ? w_diff[LW-1:0] : w_shift[LW-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

>>> sv/bbc_isqrt.sv
// Digit-by-digit floor integer square root, one root bit per cycle.
module bbc_isqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bbc_pkg::VAR_W-1:0] i_radicand,
    output logic                      o_done,
    output logic [bbc_pkg::DEV_W-1:0] o_root
);

    import bbc_pkg::*;

    localparam int REM_W = DEV_W + 2;
    localparam int CW    = $clog2(DEV_W + 1);

    logic [VAR_W-1:0] r_rad;
    logic [REM_W-1:0] r_rem;
    logic [DEV_W-1:0] r_root;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [REM_W:0]   w_rem_sh;
    logic [REM_W:0]   w_trial;
    logic             w_take;
    logic [REM_W:0]   w_sub;

    // Bring down the next two radicand bits and try root*4+1.
    assign w_rem_sh = {r_rem[REM_W-2:0], r_rad[VAR_W-1:VAR_W-2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_take   = (w_rem_sh >= w_trial);
    assign w_sub    = w_rem_sh - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DEV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[VAR_W-3:0], 2'b00};
            r_rem  <= w_take ? w_sub[REM_W-1:0] : w_rem_sh[REM_W-1:0];
            r_root <= {r_root[DEV_W-2:0], w_take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
